>>> rtl/bts_pkg.sv
// ---------------------------------------------------------------------------
// bts_pkg
// shared types, constants and melody tables of the buzzer tone sequencer
// ---------------------------------------------------------------------------
package bts_pkg;

  // default full-scale duty of the pwm tone, out of 1024
  localparam int unsigned MAX_DUTY_DEF = 512;

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned VOL_W  = 8;
  localparam int unsigned FREQ_W = 11;
  localparam int unsigned DUTY_W = 10;
  localparam int unsigned NOTE_W = 3;
  localparam int unsigned MS_W   = 8;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BEEP      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OVERHEAT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OVERPOWER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_VOL   = 3'd4;

  localparam logic [VOL_W-1:0] VOL_MAX      = 8'd100;
  localparam int unsigned      VOL_RESET    = 50;
  localparam int unsigned      PCT_ROUND    = 50;
  localparam int unsigned      PCT_SCALE    = 100;

  // x/100 as (x*RECIP)>>SHIFT, exact for x below 199728
  localparam int unsigned      DIV100_RECIP_W = 18;
  localparam logic [DIV100_RECIP_W-1:0] DIV100_RECIP = 18'd167773;
  localparam int unsigned      DIV100_SHIFT   = 24;

  localparam logic [FREQ_W-1:0] BEEP_HZ = 11'd1000;
  localparam logic [MS_W-1:0]   BEEP_MS = 8'd50;
  localparam logic [NOTE_W-1:0] LAST_NOTE = 3'd4;

  // queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // classified operation
  typedef enum logic [2:0] {
    OP_TICK,
    OP_BEEP,
    OP_MEL_HEAT,
    OP_MEL_POWER,
    OP_SET_VOL,
    OP_NONE
  } op_t;

  // melody in progress
  typedef enum logic [1:0] {
    MEL_NONE,
    MEL_HEAT,
    MEL_POWER
  } mel_t;

  // one queued beat
  typedef struct packed {
    op_t               op;
    logic              vol_zero;
    logic [DUTY_W-1:0] duty;
  } entry_t;

  // note frequency rom, zero is a rest
  function automatic logic [FREQ_W-1:0] mel_freq(input mel_t m, input logic [NOTE_W-1:0] n);
    logic [FREQ_W-1:0] f;
    f = '0;
    if (m == MEL_POWER) begin
      unique case (n)
        3'd0:    f = 11'd880;
        3'd1:    f = 11'd0;
        3'd2:    f = 11'd880;
        3'd3:    f = 11'd0;
        3'd4:    f = 11'd1175;
        default: f = 11'd880;
      endcase
    end else begin
      unique case (n)
        3'd0:    f = 11'd262;
        3'd1:    f = 11'd330;
        3'd2:    f = 11'd294;
        3'd3:    f = 11'd349;
        3'd4:    f = 11'd392;
        default: f = 11'd262;
      endcase
    end
    return f;
  endfunction

  // note length rom in ms
  function automatic logic [MS_W-1:0] mel_ms(input mel_t m, input logic [NOTE_W-1:0] n);
    logic [MS_W-1:0] d;
    d = '0;
    if (m == MEL_POWER) begin
      unique case (n)
        3'd0:    d = 8'd70;
        3'd1:    d = 8'd50;
        3'd2:    d = 8'd70;
        3'd3:    d = 8'd50;
        3'd4:    d = 8'd140;
        default: d = 8'd70;
      endcase
    end else begin
      unique case (n)
        3'd4:    d = 8'd180;
        default: d = 8'd90;
      endcase
    end
    return d;
  endfunction

endpackage

>>> rtl/bts_front.sv
// ---------------------------------------------------------------------------
// bts_front
// decodes a command beat, clamps the volume and works out its duty
// ---------------------------------------------------------------------------
module bts_front #(
  parameter int unsigned MAX_DUTY = bts_pkg::MAX_DUTY_DEF
) (
  input  logic [bts_pkg::CMD_W-1:0] command,
  input  logic [bts_pkg::VOL_W-1:0] volume,
  output bts_pkg::entry_t           entry
);

  localparam int unsigned NumMax = MAX_DUTY * bts_pkg::PCT_SCALE + bts_pkg::PCT_ROUND;
  localparam int unsigned NumW   = $clog2(NumMax + 1);
  localparam int unsigned ProdW  = NumW + bts_pkg::DIV100_RECIP_W;

  logic [bts_pkg::VOL_W-1:0] clamped;
  logic [NumW-1:0]           num;
  logic [ProdW-1:0]          prod;
  bts_pkg::op_t              op;

  // clamp to full scale
  assign clamped = (volume > bts_pkg::VOL_MAX) ? bts_pkg::VOL_MAX : volume;

  // rounded duty, division by 100 through the reciprocal
  assign num  = NumW'(MAX_DUTY) * NumW'(clamped) + NumW'(bts_pkg::PCT_ROUND);
  assign prod = ProdW'(num) * ProdW'(bts_pkg::DIV100_RECIP);

  // command classification
  always_comb begin
    unique case (command)
      bts_pkg::CMD_TICK:      op = bts_pkg::OP_TICK;
      bts_pkg::CMD_BEEP:      op = bts_pkg::OP_BEEP;
      bts_pkg::CMD_OVERHEAT:  op = bts_pkg::OP_MEL_HEAT;
      bts_pkg::CMD_OVERPOWER: op = bts_pkg::OP_MEL_POWER;
      bts_pkg::CMD_SET_VOL:   op = bts_pkg::OP_SET_VOL;
      default:                op = bts_pkg::OP_NONE;
    endcase
  end

  assign entry.op       = op;
  assign entry.vol_zero = (clamped == '0);
  assign entry.duty     = bts_pkg::DUTY_W'(prod >> bts_pkg::DIV100_SHIFT);

endmodule

>>> rtl/bts_queue.sv
// ---------------------------------------------------------------------------
// bts_queue
// short fifo of classified beats between front and back
// ---------------------------------------------------------------------------
module bts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bts_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output bts_pkg::entry_t pop_data
);

  localparam int unsigned PtrW = $clog2(bts_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(bts_pkg::QUEUE_DEPTH + 1);

  bts_pkg::entry_t mem_r [bts_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == CntW'(bts_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(bts_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(bts_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/bts_back.sv
// ---------------------------------------------------------------------------
// bts_back
// sequencer state, note timing and the registered result beat
// ---------------------------------------------------------------------------
module bts_back #(
  parameter int unsigned MAX_DUTY = bts_pkg::MAX_DUTY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  bts_pkg::entry_t            q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_sounding,
  output logic [bts_pkg::FREQ_W-1:0] out_tone_hz,
  output logic [bts_pkg::DUTY_W-1:0] out_duty,
  output logic                       out_melody_busy,
  output logic [bts_pkg::NOTE_W-1:0] out_note_position
);

  localparam logic [bts_pkg::DUTY_W-1:0] DutyReset = bts_pkg::DUTY_W'(
    (MAX_DUTY * bts_pkg::VOL_RESET + bts_pkg::PCT_ROUND) / bts_pkg::PCT_SCALE);

  logic                       tone_r, tone_nxt;
  bts_pkg::mel_t              mel_r, mel_nxt;
  logic [bts_pkg::NOTE_W-1:0] note_r, note_nxt;
  logic [bts_pkg::MS_W-1:0]   ms_r, ms_nxt;
  logic [bts_pkg::FREQ_W-1:0] freq_r, freq_nxt;
  logic [bts_pkg::DUTY_W-1:0] duty_r, duty_nxt;
  logic                       vol_zero_r, vol_zero_nxt;
  logic [bts_pkg::DUTY_W-1:0] vol_duty_r, vol_duty_nxt;
  logic                       out_valid_r;

  // note start inputs
  bts_pkg::mel_t              bn_mel;
  logic [bts_pkg::NOTE_W-1:0] bn_note;
  logic                       bn_zero;
  logic [bts_pkg::DUTY_W-1:0] bn_duty;
  logic                       bn_go;
  logic [bts_pkg::FREQ_W-1:0] bn_freq;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign bn_freq   = bts_pkg::mel_freq(bn_mel, bn_note);

  // command execution
  always_comb begin
    tone_nxt     = tone_r;
    mel_nxt      = mel_r;
    note_nxt     = note_r;
    ms_nxt       = ms_r;
    freq_nxt     = freq_r;
    duty_nxt     = duty_r;
    vol_zero_nxt = vol_zero_r;
    vol_duty_nxt = vol_duty_r;
    bn_mel       = mel_r;
    bn_note      = note_r;
    bn_zero      = vol_zero_r;
    bn_duty      = vol_duty_r;
    bn_go        = 1'b0;
    unique case (q_data.op)
      bts_pkg::OP_TICK: begin
        if (tone_r || mel_r != bts_pkg::MEL_NONE) begin
          if (ms_r > 8'd1) begin
            ms_nxt = ms_r - 1'b1;
          end else if (mel_r != bts_pkg::MEL_NONE && note_r != bts_pkg::LAST_NOTE) begin
            note_nxt = note_r + 1'b1;
            bn_note  = note_r + 1'b1;
            bn_go    = 1'b1;
          end else begin
            tone_nxt = 1'b0;
            mel_nxt  = bts_pkg::MEL_NONE;
            note_nxt = '0;
            ms_nxt   = '0;
            freq_nxt = '0;
            duty_nxt = '0;
          end
        end
      end
      bts_pkg::OP_BEEP: begin
        mel_nxt  = bts_pkg::MEL_NONE;
        note_nxt = '0;
        tone_nxt = 1'b1;
        freq_nxt = bts_pkg::BEEP_HZ;
        duty_nxt = vol_duty_r;
        ms_nxt   = bts_pkg::BEEP_MS;
      end
      bts_pkg::OP_MEL_HEAT, bts_pkg::OP_MEL_POWER: begin
        mel_nxt      = (q_data.op == bts_pkg::OP_MEL_POWER) ? bts_pkg::MEL_POWER
                                                            : bts_pkg::MEL_HEAT;
        note_nxt     = '0;
        vol_zero_nxt = q_data.vol_zero;
        vol_duty_nxt = q_data.duty;
        bn_mel       = mel_nxt;
        bn_note      = '0;
        bn_zero      = q_data.vol_zero;
        bn_duty      = q_data.duty;
        bn_go        = 1'b1;
      end
      bts_pkg::OP_SET_VOL: begin
        vol_zero_nxt = q_data.vol_zero;
        vol_duty_nxt = q_data.duty;
      end
      // ignored codes leave the state alone
      default: begin
      end
    endcase

    // start of a note, rests and zero volume stay silent
    if (bn_go) begin
      ms_nxt = bts_pkg::mel_ms(bn_mel, bn_note);
      if (bn_freq == '0 || bn_zero) begin
        tone_nxt = 1'b0;
        freq_nxt = '0;
        duty_nxt = '0;
      end else begin
        tone_nxt = 1'b1;
        freq_nxt = bn_freq;
        duty_nxt = bn_duty;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r     <= 1'b0;
      mel_r      <= bts_pkg::MEL_NONE;
      note_r     <= '0;
      ms_r       <= '0;
      freq_r     <= '0;
      duty_r     <= '0;
      vol_zero_r <= 1'b0;
      vol_duty_r <= DutyReset;
    end else if (q_pop) begin
      tone_r     <= tone_nxt;
      mel_r      <= mel_nxt;
      note_r     <= note_nxt;
      ms_r       <= ms_nxt;
      freq_r     <= freq_nxt;
      duty_r     <= duty_nxt;
      vol_zero_r <= vol_zero_nxt;
      vol_duty_r <= vol_duty_nxt;
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_sounding      <= tone_nxt;
      out_tone_hz       <= freq_nxt;
      out_duty          <= duty_nxt;
      out_melody_busy   <= (mel_nxt != bts_pkg::MEL_NONE);
      out_note_position <= note_nxt;
    end
  end

endmodule

>>> rtl/buzzer_tone_sequencer_unit.sv
// ---------------------------------------------------------------------------
// buzzer_tone_sequencer_unit
// tone sequencer for a pwm buzzer: beep, two melodies, volume, ms ticks
// ---------------------------------------------------------------------------
// a taken beat is stored in the queue, then the sequencer registers its result beat
// throughput: one command beat per cycle while result beats are taken, output stalls hold it
// a two-entry queue between decode and sequencer absorbs output stalls
// reset clears the sequencer and the queue, volume returns to fifty percent
module buzzer_tone_sequencer_unit #(
  parameter int unsigned MAX_DUTY = bts_pkg::MAX_DUTY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bts_pkg::CMD_W-1:0]  in_command,
  input  logic [bts_pkg::VOL_W-1:0]  in_volume,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_sounding,
  output logic [bts_pkg::FREQ_W-1:0] out_tone_hz,
  output logic [bts_pkg::DUTY_W-1:0] out_duty,
  output logic                       out_melody_busy,
  output logic [bts_pkg::NOTE_W-1:0] out_note_position
);

  bts_pkg::entry_t front_entry;
  bts_pkg::entry_t q_data;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // decode
  bts_front #(
    .MAX_DUTY (MAX_DUTY)
  ) u_front (
    .command (in_command),
    .volume  (in_volume),
    .entry   (front_entry)
  );

  // queue
  bts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // sequencer
  bts_back #(
    .MAX_DUTY (MAX_DUTY)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sounding      (out_sounding),
    .out_tone_hz       (out_tone_hz),
    .out_duty          (out_duty),
    .out_melody_busy   (out_melody_busy),
    .out_note_position (out_note_position)
  );

endmodule

>>> rtl/bts_checker.sv
// ---------------------------------------------------------------------------
// bts_checker
// port-level checks of the buzzer tone sequencer, bound to the top level
// ---------------------------------------------------------------------------
module bts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_sounding,
  input logic [bts_pkg::FREQ_W-1:0] out_tone_hz,
  input logic [bts_pkg::DUTY_W-1:0] out_duty,
  input logic                       out_melody_busy,
  input logic [bts_pkg::NOTE_W-1:0] out_note_position
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sounding) && $stable(out_tone_hz)
      && $stable(out_duty) && $stable(out_melody_busy) && $stable(out_note_position))
    else $error("result beat changed while stalled");

  // silent means no tone and no duty
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sounding |-> out_tone_hz == '0 && out_duty == '0)
    else $error("silent beat carries a tone");

  // a driven tone always has a frequency
  a_tone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sounding |-> out_tone_hz != '0)
    else $error("sounding beat without frequency");

  // note position only within a melody
  a_note: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_melody_busy || out_note_position == '0)
      && out_note_position <= bts_pkg::LAST_NOTE)
    else $error("bad note position");

endmodule

bind buzzer_tone_sequencer_unit bts_checker u_bts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sounding      (out_sounding),
  .out_tone_hz       (out_tone_hz),
  .out_duty          (out_duty),
  .out_melody_busy   (out_melody_busy),
  .out_note_position (out_note_position)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the buzzer tone sequencer: command beats go in over
// valid/ready with random gaps, result beats are taken with random stalls and
// each one is compared with the beat predicted by an in-bench sequencer model
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NOTES     = 5;
  localparam int unsigned RAND_BEATS = 280;

  // melody tables, note 0 on the right
  localparam logic [NOTES-1:0][bts_pkg::FREQ_W-1:0] HEAT_HZ =
    {11'd392, 11'd349, 11'd294, 11'd330, 11'd262};
  localparam logic [NOTES-1:0][bts_pkg::MS_W-1:0] HEAT_MS =
    {8'd180, 8'd90, 8'd90, 8'd90, 8'd90};
  localparam logic [NOTES-1:0][bts_pkg::FREQ_W-1:0] POWER_HZ =
    {11'd1175, 11'd0, 11'd880, 11'd0, 11'd880};
  localparam logic [NOTES-1:0][bts_pkg::MS_W-1:0] POWER_MS =
    {8'd140, 8'd50, 8'd70, 8'd50, 8'd70};

  typedef struct packed {
    logic                       sounding;
    logic [bts_pkg::FREQ_W-1:0] tone_hz;
    logic [bts_pkg::DUTY_W-1:0] duty;
    logic                       melody_busy;
    logic [bts_pkg::NOTE_W-1:0] note_position;
  } tone_beat_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [bts_pkg::CMD_W-1:0]  in_command;
  logic [bts_pkg::VOL_W-1:0]  in_volume;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_sounding;
  logic [bts_pkg::FREQ_W-1:0] out_tone_hz;
  logic [bts_pkg::DUTY_W-1:0] out_duty;
  logic                       out_melody_busy;
  logic [bts_pkg::NOTE_W-1:0] out_note_position;

  // sequencer model state
  logic                       tone_on;
  bts_pkg::mel_t              mel_sel;
  logic [bts_pkg::NOTE_W-1:0] note_idx;
  logic [bts_pkg::MS_W-1:0]   ms_left;
  logic [bts_pkg::FREQ_W-1:0] cur_freq;
  logic [bts_pkg::DUTY_W-1:0] cur_duty;
  logic [6:0]                 vol_level;

  tone_beat_t  pending_tones[$];
  int unsigned fault_count;
  logic        sender_steady;
  logic        sink_steady;
  int unsigned stall_left;
  int unsigned sink_phase;

  buzzer_tone_sequencer_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_volume         (in_volume),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sounding      (out_sounding),
    .out_tone_hz       (out_tone_hz),
    .out_duty          (out_duty),
    .out_melody_busy   (out_melody_busy),
    .out_note_position (out_note_position)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------
  // sequencer model
  // ------------------------------------------------------------------------
  function automatic logic [bts_pkg::DUTY_W-1:0] duty_for(input logic [6:0] vol);
    int unsigned scaled;
    scaled = (bts_pkg::MAX_DUTY_DEF * vol + bts_pkg::PCT_ROUND) / bts_pkg::PCT_SCALE;
    return scaled[bts_pkg::DUTY_W-1:0];
  endfunction

  function automatic void go_quiet();
    tone_on  = 1'b0;
    cur_freq = '0;
    cur_duty = '0;
  endfunction

  function automatic void halt_sequence();
    mel_sel  = bts_pkg::MEL_NONE;
    note_idx = '0;
    ms_left  = '0;
    go_quiet();
  endfunction

  function automatic void reset_model();
    halt_sequence();
    vol_level = 7'(bts_pkg::VOL_RESET);
  endfunction

  // load the current note; rests and zero volume stay silent but keep time
  function automatic void start_note();
    logic [bts_pkg::FREQ_W-1:0] hz;
    hz      = (mel_sel == bts_pkg::MEL_POWER) ? POWER_HZ[note_idx] : HEAT_HZ[note_idx];
    ms_left = (mel_sel == bts_pkg::MEL_POWER) ? POWER_MS[note_idx] : HEAT_MS[note_idx];
    if (hz == '0 || vol_level == '0) begin
      go_quiet();
    end else begin
      tone_on  = 1'b1;
      cur_freq = hz;
      cur_duty = duty_for(vol_level);
    end
  endfunction

  function automatic tone_beat_t apply_command(input logic [bts_pkg::CMD_W-1:0] cmd,
                                               input logic [bts_pkg::VOL_W-1:0] vol);
    logic [6:0] clamped;
    tone_beat_t res;
    clamped = (vol > bts_pkg::VOL_MAX) ? bts_pkg::VOL_MAX[6:0] : vol[6:0];
    case (cmd)
      bts_pkg::CMD_TICK: begin
        if (tone_on || mel_sel != bts_pkg::MEL_NONE) begin
          if (ms_left > 1) begin
            ms_left = ms_left - 1'b1;
          end else if (mel_sel != bts_pkg::MEL_NONE && int'(note_idx) + 1 < NOTES) begin
            note_idx = note_idx + 1'b1;
            start_note();
          end else begin
            halt_sequence();
          end
        end
      end
      bts_pkg::CMD_BEEP: begin
        mel_sel  = bts_pkg::MEL_NONE;
        note_idx = '0;
        tone_on  = 1'b1;
        cur_freq = bts_pkg::BEEP_HZ;
        cur_duty = duty_for(vol_level);
        ms_left  = bts_pkg::BEEP_MS;
      end
      bts_pkg::CMD_OVERHEAT, bts_pkg::CMD_OVERPOWER: begin
        mel_sel   = (cmd == bts_pkg::CMD_OVERHEAT) ? bts_pkg::MEL_HEAT : bts_pkg::MEL_POWER;
        note_idx  = '0;
        vol_level = clamped;
        start_note();
      end
      bts_pkg::CMD_SET_VOL: vol_level = clamped;
      default: ;
    endcase
    res.sounding      = tone_on;
    res.tone_hz       = tone_on ? cur_freq : '0;
    res.duty          = tone_on ? cur_duty : '0;
    res.melody_busy   = (mel_sel != bts_pkg::MEL_NONE);
    res.note_position = (mel_sel != bts_pkg::MEL_NONE) ? note_idx : '0;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // result checking and prediction, both at the rising edge
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    tone_beat_t got;
    tone_beat_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_sounding, out_tone_hz, out_duty, out_melody_busy, out_note_position};
        if (pending_tones.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result beat with nothing pending: ", $realtime,
                     "snd %0d hz %0d duty %0d busy %0d note %0d",
                     got.sounding, got.tone_hz, got.duty, got.melody_busy,
                     got.note_position);
        end else begin
          want = pending_tones.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: mismatch ", $realtime,
                       "exp snd %0d hz %0d duty %0d busy %0d note %0d",
                       want.sounding, want.tone_hz, want.duty, want.melody_busy,
                       want.note_position,
                       " / got snd %0d hz %0d duty %0d busy %0d note %0d",
                       got.sounding, got.tone_hz, got.duty, got.melody_busy,
                       got.note_position);
          end
        end
      end
      // command beat taken, predict its result
      if (in_valid && in_ready)
        pending_tones.push_back(apply_command(in_command, in_volume));
    end
  end

  // ------------------------------------------------------------------------
  // random gaps and stalls
  // ------------------------------------------------------------------------
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side stalls, with stall-free stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready   = 1'b0;
      stall_left  = 0;
      sink_phase  = 0;
      sink_steady = 1'b0;
    end else begin
      if (stall_left != 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready = 1'b1;
        if (!sink_steady && $urandom_range(0, 99) < 30)
          stall_left = gap_len();
      end
      sink_phase = sink_phase + 1;
      if (sink_phase == 150) begin
        sink_phase  = 0;
        sink_steady = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  // one command beat; entered and left at a falling edge, valid left high
  task automatic send_beat(input logic [bts_pkg::CMD_W-1:0] cmd,
                           input logic [bts_pkg::VOL_W-1:0] vol);
    int unsigned idle;
    idle = sender_steady ? 0 : gap_len();
    if (idle != 0) begin
      in_valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_command = cmd;
    in_volume  = vol;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [bts_pkg::VOL_W-1:0] rand_volume();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return bts_pkg::VOL_MAX;
    if (r < 35) return bts_pkg::VOL_MAX + 1'b1;
    if (r < 40) return '1;
    if (r < 50) return bts_pkg::VOL_W'($urandom_range(1, 10));
    return bts_pkg::VOL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [bts_pkg::VOL_W-1:0] noise_volume();
    return bts_pkg::VOL_W'($urandom_range(0, 255));
  endfunction

  // tick while idle and the unused codes
  task automatic test_idle_commands();
    send_beat(bts_pkg::CMD_TICK, '1);
    send_beat(bts_pkg::CMD_SET_VOL + 3'd1, '1);
    send_beat(bts_pkg::CMD_SET_VOL + 3'd2, '0);
    send_beat(bts_pkg::CMD_SET_VOL + 3'd3, 8'h5A);
    send_beat(bts_pkg::CMD_TICK, '0);
  endtask

  // clamping, beep at full and zero volume
  task automatic test_volume_clamp();
    send_beat(bts_pkg::CMD_BEEP, 8'hA5);
    send_beat(bts_pkg::CMD_SET_VOL, '1);
    send_beat(bts_pkg::CMD_BEEP, '0);
    send_beat(bts_pkg::CMD_SET_VOL, bts_pkg::VOL_MAX + 1'b1);
    send_beat(bts_pkg::CMD_SET_VOL, bts_pkg::VOL_MAX);
    send_beat(bts_pkg::CMD_SET_VOL, 8'd1);
    send_beat(bts_pkg::CMD_BEEP, '0);
    send_beat(bts_pkg::CMD_SET_VOL, '0);
    send_beat(bts_pkg::CMD_BEEP, '1);
    send_beat(bts_pkg::CMD_TICK, '0);
  endtask

  // silent melody, restart, cancel by beep, melody over a beep
  task automatic test_melody_switching();
    send_beat(bts_pkg::CMD_OVERHEAT, '0);
    send_beat(bts_pkg::CMD_TICK, '0);
    send_beat(bts_pkg::CMD_OVERPOWER, '1);
    send_beat(bts_pkg::CMD_SET_VOL, 8'd1);
    send_beat(bts_pkg::CMD_TICK, '1);
    send_beat(bts_pkg::CMD_BEEP, '0);
    send_beat(bts_pkg::CMD_OVERHEAT, 8'd37);
    send_beat(bts_pkg::CMD_TICK, '0);
    send_beat(bts_pkg::CMD_OVERHEAT, bts_pkg::VOL_MAX + 1'b1);
  endtask

  // overpower melody played to its end back to back, volume changed now and then
  task automatic test_melody_playout();
    int unsigned ticks;
    int unsigned total;
    sender_steady = 1'b1;
    send_beat(bts_pkg::CMD_OVERPOWER, rand_volume());
    total = 380;
    ticks = 0;
    while (ticks < total + 3) begin
      if ($urandom_range(0, 99) < 3) begin
        send_beat(bts_pkg::CMD_SET_VOL, rand_volume());
      end else begin
        send_beat(bts_pkg::CMD_TICK, noise_volume());
        ticks++;
      end
    end
    sender_steady = 1'b0;
  endtask

  // mostly melodies and beeps followed by runs of ticks, plus noise
  task automatic test_random_traffic();
    int unsigned done;
    int unsigned kind;
    int unsigned run;
    done = 0;
    while (done < RAND_BEATS) begin
      sender_steady = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_beat($urandom_range(0, 1) ? bts_pkg::CMD_OVERHEAT : bts_pkg::CMD_OVERPOWER,
                  rand_volume());
        done++;
        run = ($urandom_range(0, 2) == 0) ? $urandom_range(80, 300) : $urandom_range(1, 80);
        for (int i = 0; i < run && done < RAND_BEATS; i++) begin
          if ($urandom_range(0, 99) < 4)
            send_beat(bts_pkg::CMD_SET_VOL, rand_volume());
          else
            send_beat(bts_pkg::CMD_TICK, noise_volume());
          done++;
        end
      end else if (kind < 65) begin
        send_beat(bts_pkg::CMD_BEEP, noise_volume());
        done++;
        run = $urandom_range(1, 60);
        for (int i = 0; i < run && done < RAND_BEATS; i++) begin
          send_beat(bts_pkg::CMD_TICK, noise_volume());
          done++;
        end
      end else if (kind < 80) begin
        send_beat(bts_pkg::CMD_SET_VOL, rand_volume());
        done++;
      end else if (kind < 92) begin
        send_beat(bts_pkg::CMD_TICK, noise_volume());
        done++;
      end else begin
        // ignored codes, not counted
        send_beat(bts_pkg::CMD_SET_VOL + 3'($urandom_range(1, 3)), noise_volume());
      end
    end
    sender_steady = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = bts_pkg::CMD_TICK;
    in_volume     = '0;
    fault_count   = 0;
    sender_steady = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_idle_commands();
    test_volume_clamp();
    test_melody_switching();
    test_melody_playout();
    test_random_traffic();
    in_valid = 1'b0;

    // drain, then wait on for stray beats
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fault_count == 0 && pending_tones.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
